// File: hw/rtl/assert_macros.svh
// Assertion macros for the top-level RTL file of the ordered array block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define OAIS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication, switched off while reset is held.
`define OAIS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/oais_pkg.sv
// Types, codes and sizes shared by the ordered array insert/remove/search block.
package oais_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 11;
    localparam int CNT_W    = 11;
    localparam int STAT_W   = 2;
    localparam int FOUND_W  = 11;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    localparam logic [CNT_W-1:0]   CAP_COUNT = CNT_W'(CAPACITY);
    localparam logic [FOUND_W-1:0] NOT_FOUND = '1;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_END   = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_REM_FIRST = 3'd3,
        OP_REM_LAST  = 3'd4,
        OP_REM_AT    = 3'd5,
        OP_SEARCH    = 3'd6
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        status_t             status;
        logic [FOUND_W-1:0]  found_at;
        logic [CNT_W-1:0]    count;
    } result_t;

    typedef struct packed {
        logic idle;
        logic done;
    } ctrl_stat_t;

endpackage

// File: hw/rtl/oais_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module oais_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/oais_ctrl.sv
// Sequencer that walks the element RAM for shifts and searches, one entry a cycle.
module oais_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [oais_pkg::OP_W-1:0]           op,
    input  logic [oais_pkg::DATA_W-1:0]         value,
    input  logic [oais_pkg::POS_W-1:0]          position,
    input  logic                                take,
    output oais_pkg::ctrl_stat_t                stat,
    output oais_pkg::result_t                   res,
    output logic                                ram_we,
    output logic [oais_pkg::ADDR_W-1:0]         ram_waddr,
    output logic [oais_pkg::DATA_W-1:0]         ram_wdata,
    output logic [oais_pkg::ADDR_W-1:0]         ram_raddr,
    input  logic [oais_pkg::DATA_W-1:0]         ram_rdata
);

    import oais_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_UP   = 5'b00010,
        S_DN   = 5'b00100,
        S_SRCH = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W-1:0]   end_reg, end_next;
    logic                issuing_reg, issuing_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic [DATA_W-1:0]   value_reg, value_next;
    status_t             status_reg, status_next;
    logic [FOUND_W-1:0]  found_reg, found_next;
    logic [CNT_W-1:0]    at_ins;
    logic [CNT_W-1:0]    at_rem;
    logic [CNT_W-1:0]    count_dec;

    assign count_dec = CNT_W'(count_reg - 1'b1);

    always_comb
    begin
        priority case (op)
            OP_INS_FRONT: at_ins = '0;
            OP_INS_END:   at_ins = count_reg;
            default:      at_ins = CNT_W'(position);
        endcase
        priority case (op)
            OP_REM_FIRST: at_rem = '0;
            OP_REM_LAST:  at_rem = count_dec;
            default:      at_rem = CNT_W'(position);
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_ptr_next     = rd_ptr_reg;
        end_next        = end_reg;
        issuing_next    = issuing_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        value_next      = value_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        ram_we          = 1'b0;
        ram_waddr       = pend_addr_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = rd_ptr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    value_next  = value;
                    status_next = ST_OK;
                    found_next  = NOT_FOUND;
                    state_next  = S_DONE;
                    priority case (op)
                        OP_INS_FRONT, OP_INS_END, OP_INS_AT:
                        begin
                            if (count_reg >= CAP_COUNT)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (at_ins > count_reg)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (at_ins == count_reg)
                            begin
                                // Appending needs no shift: write straight away.
                                ram_we     = 1'b1;
                                ram_waddr  = at_ins[ADDR_W-1:0];
                                ram_wdata  = value;
                                count_next = CNT_W'(count_reg + 1'b1);
                            end
                            else
                            begin
                                rd_ptr_next  = count_dec[ADDR_W-1:0];
                                end_next     = at_ins[ADDR_W-1:0];
                                issuing_next = 1'b1;
                                state_next   = S_UP;
                            end
                        end
                        OP_REM_FIRST, OP_REM_LAST, OP_REM_AT:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (at_rem >= count_reg)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (at_rem == count_dec)
                            begin
                                count_next = count_dec;
                            end
                            else
                            begin
                                rd_ptr_next  = ADDR_W'(at_rem[ADDR_W-1:0] + 1'b1);
                                end_next     = count_dec[ADDR_W-1:0];
                                issuing_next = 1'b1;
                                state_next   = S_DN;
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (count_reg != '0)
                            begin
                                rd_ptr_next  = '0;
                                end_next     = count_dec[ADDR_W-1:0];
                                issuing_next = 1'b1;
                                state_next   = S_SRCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_UP, S_DN, S_SRCH:
            begin
                // Read side: one address a beat, towards the end address.
                if (issuing_reg)
                begin
                    pend_valid_next = 1'b1;
                    pend_addr_next  = rd_ptr_reg;
                    if (rd_ptr_reg == end_reg)
                    begin
                        issuing_next = 1'b0;
                    end
                    else if (state_reg == S_UP)
                    begin
                        rd_ptr_next = ADDR_W'(rd_ptr_reg - 1'b1);
                    end
                    else
                    begin
                        rd_ptr_next = ADDR_W'(rd_ptr_reg + 1'b1);
                    end
                end

                // Data side: the word read last cycle is moved or compared.
                if (state_reg == S_SRCH)
                begin
                    if (pend_valid_reg && (ram_rdata == value_reg))
                    begin
                        found_next      = FOUND_W'(pend_addr_reg);
                        issuing_next    = 1'b0;
                        pend_valid_next = 1'b0;
                        state_next      = S_DONE;
                    end
                    else if (!issuing_reg && !pend_valid_reg)
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (pend_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = (state_reg == S_UP) ? ADDR_W'(pend_addr_reg + 1'b1)
                                                    : ADDR_W'(pend_addr_reg - 1'b1);
                end
                else if (!issuing_reg)
                begin
                    if (state_reg == S_UP)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = end_reg;
                        ram_wdata  = value_reg;
                        count_next = CNT_W'(count_reg + 1'b1);
                    end
                    else
                    begin
                        count_next = count_dec;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            issuing_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            issuing_reg    <= issuing_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg    <= rd_ptr_next;
        end_reg       <= end_next;
        pend_addr_reg <= pend_addr_next;
        value_reg     <= value_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
    end

    assign stat.idle    = (state_reg == S_IDLE);
    assign stat.done    = (state_reg == S_DONE);
    assign res.status   = status_reg;
    assign res.found_at = found_reg;
    assign res.count    = count_reg;

endmodule

// File: hw/rtl/ordered_array_insert_remove_search.sv
// Ordered array of signed 32-bit values with insert, remove and search on a stream port.
// Each request beat yields exactly one result beat. The list lives in a 1024-entry RAM
// with one write and one registered read port, and a single sequencer walks it one entry
// a cycle. An insert at position p moves count-p entries and a remove at p moves
// count-p-1 entries. A search reads entries from index 0 until it matches or passes the
// last entry. Appends, removes of the last entry, searches of an empty list and rejected
// requests need no walk of the RAM. A new request is taken once the previous one has
// finished; its result may still be waiting in the output register at that time.
module ordered_array_insert_remove_search (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // op [2:0], value [34:3], position [45:35], zero [47:46]
    input  logic [oais_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status [1:0], found_at [12:2], count [23:13]
    output logic [oais_pkg::M_TDATA_W-1:0]    m_tdata
);

    import oais_pkg::*;

    `include "assert_macros.svh"

    ctrl_stat_t          stat;
    result_t             res;
    logic                take;
    logic                accept;
    logic                m_tvalid_reg, m_tvalid_next;
    result_t             out_reg;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;
    logic                shown_match;

    assign s_tready = stat.idle;
    assign accept   = s_tvalid && s_tready;
    assign take     = stat.done && (!m_tvalid_reg || m_tready);

    oais_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .op        (s_tdata[OP_W-1:0]),
        .value     (s_tdata[OP_W+DATA_W-1:OP_W]),
        .position  (s_tdata[OP_W+DATA_W+POS_W-1:OP_W+DATA_W]),
        .take      (take),
        .stat      (stat),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    oais_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The output register frees the sequencer as soon as a result is captured.
    always_comb
    begin
        if (take)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.count, out_reg.found_at, out_reg.status};

    assign shown_match = m_tvalid_reg && (out_reg.found_at != NOT_FOUND);

    `OAIS_ASSERT(a_count_bound, !m_tvalid_reg || (out_reg.count <= CAP_COUNT), "count beyond capacity")
    `OAIS_ASSERT_IMP(a_busy_after_accept, accept, ##1 !s_tready, "second beat taken while busy")
    `OAIS_ASSERT_IMP(a_found_only_ok, shown_match, out_reg.status == ST_OK, "match with error status")
    `OAIS_ASSERT_IMP(a_take_shows, take, ##1 m_tvalid_reg, "captured result not presented")

endmodule
